/* sv/mf3_pkg.sv */
// Shared types, constants and compare helpers for the 3x3 median filter.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package mf3_pkg;

    localparam int MAX_WIDTH = 2048;
    localparam int PIX_W     = 8;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = 12;
    localparam int WREG_W    = 12;
    localparam int HREG_W    = 13;
    localparam int YCNT_W    = 13;

    localparam logic [WREG_W-1:0] WIDTH_RESET  = WREG_W'(640);
    localparam logic [HREG_W-1:0] HEIGHT_RESET = HREG_W'(480);
    localparam logic [WREG_W-1:0] WIDTH_MAX    = WREG_W'(MAX_WIDTH);
    localparam logic [HREG_W-1:0] HEIGHT_MAX   = HREG_W'(4096);

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam int WIN_N = 9;

    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } reg_idx_t;

    typedef enum logic {
        KIND_PIXEL = 1'b0,
        KIND_FLUSH = 1'b1
    } kind_t;

    typedef logic [PIX_W-1:0] pix_t;

    typedef struct packed {
        logic             is_pix;
        logic [COL_W-1:0] addr;
        pix_t             pixel;
        logic             emit0;
        logic             emit1;
        logic             interior;
        logic             frame_last;
        logic [COL_W-1:0] col0;
        logic [ROW_W-1:0] row;
    } q_entry_t;

    typedef struct packed {
        logic             emit0;
        logic             emit1;
        logic             interior;
        logic             frame_last;
        logic [COL_W-1:0] col0;
        logic [COL_W-1:0] col1;
        logic [ROW_W-1:0] row;
        pix_t             pass0;
        pix_t             pass1;
    } carry_t;

    typedef struct packed {
        logic             rd_en;
        logic [COL_W-1:0] rd_addr;
        logic             wr_en;
        logic [COL_W-1:0] wr_addr;
        pix_t             wr_up;
        pix_t             wr_mid;
    } ls_req_t;

    typedef struct packed {
        pix_t up;
        pix_t mid;
    } ls_data_t;

    function automatic pix_t min3(pix_t a, pix_t b, pix_t c);
        pix_t m;
        m = (a < b) ? a : b;
        return (c < m) ? c : m;
    endfunction

    function automatic pix_t max3(pix_t a, pix_t b, pix_t c);
        pix_t m;
        m = (a > b) ? a : b;
        return (c > m) ? c : m;
    endfunction

    function automatic pix_t med3(pix_t a, pix_t b, pix_t c);
        pix_t lo;
        pix_t hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        return (c < lo) ? lo : ((c > hi) ? hi : c);
    endfunction

endpackage

`default_nettype wire

/* sv/mf3_front.sv */
// Front end: raster position counters, item classification and request issue.
// Depends on mf3_pkg; feeds mf3_queue.
`default_nettype none

module mf3_front (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic                       s_kind,
    input  wire logic [mf3_pkg::PIX_W-1:0]  s_pixel_value,
    input  wire logic [mf3_pkg::WREG_W-1:0] width_cfg,
    input  wire logic [mf3_pkg::HREG_W-1:0] height_cfg,
    input  wire logic                       q_full,
    input  wire logic                       clearing,
    output logic                            q_push,
    output mf3_pkg::q_entry_t               q_data
);
    import mf3_pkg::*;

    logic [COL_W-1:0]  x_reg, x_next;
    logic [COL_W-1:0]  c_reg, c_next;
    logic [YCNT_W-1:0] y_reg, y_next;
    logic [WREG_W-1:0] w_eff, w_m1, x_ext, c_ext;
    logic [HREG_W-1:0] h_eff, h_m1;
    logic [YCNT_W-1:0] y_m1;
    logic              is_flush, active, end_row, flush_last, interior;

    always_comb begin
        w_eff = width_cfg;
        if (width_cfg == '0) begin
            w_eff = WREG_W'(1);
        end else if (width_cfg > WIDTH_MAX) begin
            w_eff = WIDTH_MAX;
        end
        h_eff = height_cfg;
        if (height_cfg == '0) begin
            h_eff = HREG_W'(1);
        end else if (height_cfg > HEIGHT_MAX) begin
            h_eff = HEIGHT_MAX;
        end
    end

    assign w_m1  = w_eff - WREG_W'(1);
    assign h_m1  = h_eff - HREG_W'(1);
    assign y_m1  = y_reg - YCNT_W'(1);
    assign x_ext = WREG_W'(x_reg);
    assign c_ext = WREG_W'(c_reg);

    assign is_flush   = (s_kind == KIND_FLUSH);
    assign active     = is_flush ? (y_reg >= h_eff) : (y_reg < h_eff);
    assign end_row    = (x_ext >= w_m1);
    assign flush_last = (c_ext >= w_m1);
    assign interior   = (x_reg >= COL_W'(2)) && (y_reg >= YCNT_W'(2)) &&
                        ((w_eff == WREG_W'(1)) || (x_ext + WREG_W'(1) <= w_eff));

    assign s_ready = !q_full && !clearing;
    assign q_push  = s_valid && s_ready && active;

    always_comb begin
        q_data.is_pix     = !is_flush;
        q_data.addr       = is_flush ? c_reg : x_reg;
        q_data.pixel      = s_pixel_value;
        q_data.emit0      = is_flush || ((y_reg != '0) && (x_reg != '0));
        q_data.emit1      = !is_flush && (y_reg != '0) && end_row;
        q_data.interior   = !is_flush && interior;
        q_data.frame_last = is_flush && flush_last;
        q_data.col0       = is_flush ? c_reg : (x_reg - COL_W'(1));
        q_data.row        = is_flush ? h_m1[ROW_W-1:0] : y_m1[ROW_W-1:0];
    end

    always_comb begin
        x_next = x_reg;
        y_next = y_reg;
        c_next = c_reg;
        if (q_push) begin
            if (is_flush) begin
                if (flush_last) begin
                    c_next = '0;
                    x_next = '0;
                    y_next = '0;
                end else begin
                    c_next = c_reg + COL_W'(1);
                end
            end else if (end_row) begin
                x_next = '0;
                y_next = y_reg + YCNT_W'(1);
            end else begin
                x_next = x_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg <= '0;
            y_reg <= '0;
            c_reg <= '0;
        end else begin
            x_reg <= x_next;
            y_reg <= y_next;
            c_reg <= c_next;
        end
    end

endmodule

`default_nettype wire

/* sv/mf3_queue.sv */
// Short request queue between the front end and the back end.
// Depends on mf3_pkg for the entry type and depth.
`default_nettype none

module mf3_queue (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         push,
    input  mf3_pkg::q_entry_t push_data,
    input  wire logic         pop,
    output mf3_pkg::q_entry_t head,
    output logic              not_empty,
    output logic              full
);
    import mf3_pkg::*;

    q_entry_t             entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0]   count_reg, count_next;
    logic                 do_pop;

    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign head      = entry_reg[rd_ptr_reg];
    assign do_pop    = pop && not_empty;

    always_comb begin
        count_next = count_reg;
        if (push && !do_pop) begin
            count_next = count_reg + Q_CNT_W'(1);
        end else if (!push && do_pop) begin
            count_next = count_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

/* sv/mf3_line_store.sv */
// Upper and middle line stores with registered read, write bypass and
// power-up clearing sweep. Depends on mf3_pkg.
`default_nettype none

module mf3_line_store (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  mf3_pkg::ls_req_t  req,
    output mf3_pkg::ls_data_t rdata,
    output logic              clearing
);
    import mf3_pkg::*;

    pix_t             up_mem  [MAX_WIDTH];
    pix_t             mid_mem [MAX_WIDTH];
    ls_data_t         rd_reg, fwd_reg;
    logic             hit_reg;
    logic             clr_reg;
    logic [COL_W-1:0] clr_addr_reg;
    logic             wen;
    logic [COL_W-1:0] waddr;
    pix_t             wup, wmid;

    always_comb begin
        if (clr_reg) begin
            wen   = 1'b1;
            waddr = clr_addr_reg;
            wup   = '0;
            wmid  = '0;
        end else begin
            wen   = req.wr_en;
            waddr = req.wr_addr;
            wup   = req.wr_up;
            wmid  = req.wr_mid;
        end
    end

    always_ff @(posedge aclk) begin
        if (wen) begin
            up_mem[waddr]  <= wup;
            mid_mem[waddr] <= wmid;
        end
        if (req.rd_en) begin
            rd_reg.up  <= up_mem[req.rd_addr];
            rd_reg.mid <= mid_mem[req.rd_addr];
            fwd_reg.up  <= wup;
            fwd_reg.mid <= wmid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg      <= 1'b0;
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            if (req.rd_en) begin
                hit_reg <= wen && (waddr == req.rd_addr);
            end
            if (clr_reg) begin
                clr_addr_reg <= clr_addr_reg + COL_W'(1);
                if (clr_addr_reg == '1) begin
                    clr_reg <= 1'b0;
                end
            end
        end
    end

    assign rdata    = hit_reg ? fwd_reg : rd_reg;
    assign clearing = clr_reg;

endmodule

`default_nettype wire

/* sv/mf3_back.sv */
// Back end: line store access, 3x3 window, pipelined median and result
// register. Depends on mf3_pkg; drives mf3_line_store.
`default_nettype none

module mf3_back (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  mf3_pkg::q_entry_t              q_head,
    input  wire logic                      q_not_empty,
    output logic                           q_pop,
    output mf3_pkg::ls_req_t               ls_req,
    input  mf3_pkg::ls_data_t              ls_rdata,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic [mf3_pkg::PIX_W-1:0]      m_filtered_value,
    output logic [mf3_pkg::COL_W-1:0]      m_out_col,
    output logic [mf3_pkg::ROW_W-1:0]      m_out_row,
    output logic                           m_run_last,
    output logic                           m_frame_last
);
    import mf3_pkg::*;

    logic     adv, last_showing;
    q_entry_t s1_reg;
    logic     v1_reg, v2_reg, v3_reg, v4_reg;
    carry_t   carry1, c2_reg, c3_reg, c4_reg;
    pix_t     win_reg  [WIN_N];
    pix_t     win_next [WIN_N];
    pix_t     sort_reg [WIN_N];
    pix_t     abc_reg  [3];

    logic             o_valid_reg, o_valid_next;
    logic             o_first_reg, o_first_next;
    logic             o_second_reg, o_second_next;
    logic             o_fl_reg;
    pix_t             o_val0_reg, o_val1_reg;
    logic [COL_W-1:0] o_col0_reg, o_col1_reg;
    logic [ROW_W-1:0] o_row_reg;

    assign last_showing = !(o_first_reg && o_second_reg);
    assign adv          = !(o_valid_reg && !(m_ready && last_showing));
    assign q_pop        = adv && q_not_empty;

    always_comb begin
        ls_req.rd_en   = adv;
        ls_req.rd_addr = q_head.addr;
        ls_req.wr_en   = adv && v1_reg && s1_reg.is_pix;
        ls_req.wr_addr = s1_reg.addr;
        ls_req.wr_up   = ls_rdata.mid;
        ls_req.wr_mid  = s1_reg.pixel;
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            win_next[r*3]   = win_reg[r*3+1];
            win_next[r*3+1] = win_reg[r*3+2];
        end
        win_next[2] = ls_rdata.up;
        win_next[5] = ls_rdata.mid;
        win_next[8] = s1_reg.pixel;
    end

    always_comb begin
        carry1.emit0      = s1_reg.emit0;
        carry1.emit1      = s1_reg.emit1;
        carry1.interior   = s1_reg.interior;
        carry1.frame_last = s1_reg.frame_last;
        carry1.col0       = s1_reg.col0;
        carry1.col1       = s1_reg.addr;
        carry1.row        = s1_reg.row;
        carry1.pass0      = s1_reg.is_pix ? win_reg[5] : ls_rdata.mid;
        carry1.pass1      = ls_rdata.mid;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_reg <= q_head;
            c2_reg <= carry1;
            c3_reg <= c2_reg;
            c4_reg <= c3_reg;
            if (v1_reg && s1_reg.is_pix) begin
                for (int i = 0; i < WIN_N; i++) begin
                    win_reg[i] <= win_next[i];
                end
            end
            for (int r = 0; r < 3; r++) begin
                sort_reg[r*3]   <= min3(win_reg[r*3], win_reg[r*3+1], win_reg[r*3+2]);
                sort_reg[r*3+1] <= med3(win_reg[r*3], win_reg[r*3+1], win_reg[r*3+2]);
                sort_reg[r*3+2] <= max3(win_reg[r*3], win_reg[r*3+1], win_reg[r*3+2]);
            end
            abc_reg[0] <= max3(sort_reg[0], sort_reg[3], sort_reg[6]);
            abc_reg[1] <= med3(sort_reg[1], sort_reg[4], sort_reg[7]);
            abc_reg[2] <= min3(sort_reg[2], sort_reg[5], sort_reg[8]);
            o_val0_reg <= c4_reg.interior ? med3(abc_reg[0], abc_reg[1], abc_reg[2])
                                          : c4_reg.pass0;
            o_val1_reg <= c4_reg.pass1;
            o_col0_reg <= c4_reg.col0;
            o_col1_reg <= c4_reg.col1;
            o_row_reg  <= c4_reg.row;
            o_fl_reg   <= c4_reg.frame_last;
        end
    end

    always_comb begin
        o_valid_next  = o_valid_reg;
        o_first_next  = o_first_reg;
        o_second_next = o_second_reg;
        if (adv) begin
            o_valid_next  = v4_reg && (c4_reg.emit0 || c4_reg.emit1);
            o_first_next  = c4_reg.emit0;
            o_second_next = c4_reg.emit1;
        end else if (m_ready) begin
            o_first_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            o_valid_reg  <= 1'b0;
            o_first_reg  <= 1'b0;
            o_second_reg <= 1'b0;
        end else begin
            if (adv) begin
                v1_reg <= q_not_empty;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
                v4_reg <= v3_reg;
            end
            o_valid_reg  <= o_valid_next;
            o_first_reg  <= o_first_next;
            o_second_reg <= o_second_next;
        end
    end

    assign m_valid          = o_valid_reg;
    assign m_filtered_value = o_first_reg ? o_val0_reg : o_val1_reg;
    assign m_out_col        = o_first_reg ? o_col0_reg : o_col1_reg;
    assign m_out_row        = o_row_reg;
    assign m_run_last       = last_showing;
    assign m_frame_last     = o_first_reg && o_fl_reg;

endmodule

`default_nettype wire

/* sv/median_filter_3x3_unit.sv */
// 3x3 median filter top level: APB register file, front end, request queue,
// line stores and back end. Depends on mf3_pkg and all mf3_* modules.
//
// Usage:
//   Input channel s_*: one pixel (s_kind pixel) per request in raster order,
//   or a flush request once the frame is in; flush requests emit the last
//   row, one pixel each. Output channel m_*: filtered pixel with its column
//   and row; m_run_last marks the last result of a request, m_frame_last the
//   final pixel of the frame. From the second row on, pixels of the last
//   column give two results when the width is above one.
//   Throughput: one request per cycle while the receiver takes results; a
//   request with two results holds the back end at the result register until its first result is taken.
//   The median runs as a 3-stage compare network behind a registered line
//   store read; line stores are one read and one write per cycle.
//   Reset: registers return to 640 x 480 and the line stores are swept to
//   zero, one column per cycle over all 2048 columns, with s_ready low; APB
//   writes are taken during the sweep.
//   Receiver stall: the back end holds in place, the 4-deep request queue
//   absorbs further requests, then s_ready drops.
`default_nettype none

module median_filter_3x3_unit (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [mf3_pkg::APB_AW-1:0] paddr,
    input  wire logic [mf3_pkg::APB_DW-1:0] pwdata,
    output logic      [mf3_pkg::APB_DW-1:0] prdata,
    output logic                            pready,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic                       s_kind,
    input  wire logic [mf3_pkg::PIX_W-1:0]  s_pixel_value,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic      [mf3_pkg::PIX_W-1:0]  m_filtered_value,
    output logic      [mf3_pkg::COL_W-1:0]  m_out_col,
    output logic      [mf3_pkg::ROW_W-1:0]  m_out_row,
    output logic                            m_run_last,
    output logic                            m_frame_last
);
    import mf3_pkg::*;

    logic [WREG_W-1:0] width_reg;
    logic [HREG_W-1:0] height_reg;
    reg_idx_t          reg_idx;
    logic              cfg_wr;

    q_entry_t q_data, q_head;
    logic     q_push, q_pop, q_not_empty, q_full, clearing;
    ls_req_t  ls_req;
    ls_data_t ls_rdata;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_WIDTH: begin
                    width_reg <= pwdata[WREG_W-1:0];
                end
                REG_HEIGHT: begin
                    height_reg <= pwdata[HREG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_WIDTH:  prdata = APB_DW'(width_reg);
            REG_HEIGHT: prdata = APB_DW'(height_reg);
            default:    prdata = '0;
        endcase
    end

    mf3_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_pixel_value (s_pixel_value),
        .width_cfg     (width_reg),
        .height_cfg    (height_reg),
        .q_full        (q_full),
        .clearing      (clearing),
        .q_push        (q_push),
        .q_data        (q_data)
    );

    mf3_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_data),
        .pop       (q_pop),
        .head      (q_head),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    mf3_line_store u_line_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (ls_req),
        .rdata    (ls_rdata),
        .clearing (clearing)
    );

    mf3_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_head           (q_head),
        .q_not_empty      (q_not_empty),
        .q_pop            (q_pop),
        .ls_req           (ls_req),
        .ls_rdata         (ls_rdata),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_filtered_value (m_filtered_value),
        .m_out_col        (m_out_col),
        .m_out_row        (m_out_row),
        .m_run_last       (m_run_last),
        .m_frame_last     (m_frame_last)
    );

endmodule

`default_nettype wire

/* sv/mf3_checker.sv */
// Port-level checks for the 3x3 median filter, bound to the top level.
// Depends on mf3_pkg and median_filter_3x3_unit.
`default_nettype none

module mf3_checker (
    input wire logic                      aclk,
    input wire logic                      aresetn,
    input wire logic                      s_ready,
    input wire logic                      m_valid,
    input wire logic                      m_ready,
    input wire logic [mf3_pkg::PIX_W-1:0] m_filtered_value,
    input wire logic [mf3_pkg::COL_W-1:0] m_out_col,
    input wire logic [mf3_pkg::ROW_W-1:0] m_out_row,
    input wire logic                      m_run_last,
    input wire logic                      m_frame_last
);
    import mf3_pkg::*;

    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    a_payload_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_filtered_value) && $stable(m_out_col) &&
                                $stable(m_out_row))
        else $error("result changed while stalled");

    a_sweep_blocks_input: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("request taken during line store sweep");

    a_row_end_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_run_last |=>
            m_valid && (m_out_row == $past(m_out_row)) &&
            (m_out_col == $past(m_out_col) + COL_W'(1)))
        else $error("second result of a row end is missing or misplaced");

    a_frame_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_last |-> m_run_last)
        else $error("frame end not on the last result of its request");

endmodule

bind median_filter_3x3_unit mf3_checker u_mf3_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_filtered_value (m_filtered_value),
    .m_out_col        (m_out_col),
    .m_out_row        (m_out_row),
    .m_run_last       (m_run_last),
    .m_frame_last     (m_frame_last)
);

`default_nettype wire
